### hdl/jcm_pkg.sv
// Shared types and constants of the joystick calibrate-and-map block.
package jcm_pkg;

  // Mapped axis range and the width of the scaled output span.
  localparam logic signed [7:0] AXIS_MAX   = 8'sd127;
  localparam logic signed [7:0] AXIS_MIN   = -8'sd127;
  localparam int unsigned       SCALE_SPAN = 254;

  // Item sequencer of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PITCH_GO,
    ST_PITCH_WAIT,
    ST_ROLL_GO,
    ST_ROLL_WAIT,
    ST_LOAD
  } jcm_state_e;

  // Bit-serial divider sequencer.
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_RUN,
    DV_DONE
  } jcm_div_state_e;

  // Status handed from the divider to the sequencer.
  typedef struct packed {
    logic done;
    logic zero_span;
  } jcm_div_stat_t;

endpackage

### hdl/jcm_if.sv
// Valid/ready channel interfaces for sample beats and report beats.
interface jcm_in_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic                   button_released;
  logic [SAMPLE_BITS-1:0] pitch_sample;
  logic [SAMPLE_BITS-1:0] roll_sample;

  modport source (output valid, button_released, pitch_sample, roll_sample, input ready);
  modport sink   (input valid, button_released, pitch_sample, roll_sample, output ready);
endinterface

interface jcm_out_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic                  report_valid;
  logic signed [7:0]     x_axis;
  logic signed [7:0]     y_axis;
  logic                  in_calibration;
  logic                  save_strobe;
  logic [SAMPLE_BITS:0]  saved_pitch_low;
  logic [SAMPLE_BITS:0]  saved_pitch_high;
  logic [SAMPLE_BITS:0]  saved_roll_low;
  logic [SAMPLE_BITS:0]  saved_roll_high;
  logic                  span_error;

  modport source (
    output valid, report_valid, x_axis, y_axis, in_calibration, save_strobe,
           saved_pitch_low, saved_pitch_high, saved_roll_low, saved_roll_high, span_error,
    input  ready
  );
  modport sink (
    input  valid, report_valid, x_axis, y_axis, in_calibration, save_strobe,
           saved_pitch_low, saved_pitch_high, saved_roll_low, saved_roll_high, span_error,
    output ready
  );
endinterface

### hdl/jcm_bounds.sv
// Running minimum and maximum bounds of both axes, widened during calibration.
module jcm_bounds #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   update_i,
  input  logic [SAMPLE_BITS-1:0] pitch_i,
  input  logic [SAMPLE_BITS-1:0] roll_i,
  output logic [SAMPLE_BITS:0]   pitch_low_o,
  output logic [SAMPLE_BITS:0]   pitch_high_o,
  output logic [SAMPLE_BITS:0]   roll_low_o,
  output logic [SAMPLE_BITS:0]   roll_high_o
);

  localparam int BW = SAMPLE_BITS + 1;
  localparam logic [BW-1:0] LOW_RESET = BW'(1) << SAMPLE_BITS;

  logic [BW-1:0] pitch_low_q, pitch_low_d, pitch_high_q, pitch_high_d;
  logic [BW-1:0] roll_low_q, roll_low_d, roll_high_q, roll_high_d;
  logic [BW-1:0] pitch_ext, roll_ext;

  assign pitch_ext = {1'b0, pitch_i};
  assign roll_ext  = {1'b0, roll_i};

  always_comb begin
    pitch_low_d  = pitch_low_q;
    pitch_high_d = pitch_high_q;
    roll_low_d   = roll_low_q;
    roll_high_d  = roll_high_q;
    if (update_i) begin
      if (pitch_ext < pitch_low_q)  pitch_low_d  = pitch_ext;
      if (pitch_ext > pitch_high_q) pitch_high_d = pitch_ext;
      if (roll_ext < roll_low_q)    roll_low_d   = roll_ext;
      if (roll_ext > roll_high_q)   roll_high_d  = roll_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_low_q  <= LOW_RESET;
      pitch_high_q <= '0;
      roll_low_q   <= LOW_RESET;
      roll_high_q  <= '0;
    end else begin
      pitch_low_q  <= pitch_low_d;
      pitch_high_q <= pitch_high_d;
      roll_low_q   <= roll_low_d;
      roll_high_q  <= roll_high_d;
    end
  end

  assign pitch_low_o  = pitch_low_q;
  assign pitch_high_o = pitch_high_q;
  assign roll_low_o   = roll_low_q;
  assign roll_high_o  = roll_high_q;

endmodule

### hdl/jcm_serial_div.sv
// Bit-serial restoring divider that maps one sample onto the signed axis range.
module jcm_serial_div #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS:0]   low_i,
  input  logic [SAMPLE_BITS:0]   high_i,
  output logic signed [7:0]      value_o,
  output jcm_pkg::jcm_div_stat_t stat_o
);

  localparam int DW = SAMPLE_BITS + 2;   // signed differences
  localparam int MW = SAMPLE_BITS + 1;   // magnitudes and remainder
  localparam int NW = SAMPLE_BITS + 8;   // scaled numerator and quotient
  localparam int CW = $clog2(NW);
  localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);

  jcm_pkg::jcm_div_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [DW-1:0] diff_q, span_q;
  logic [MW-1:0] dmag_q, rem_q;
  logic [NW-1:0] quo_q;
  logic          neg_q, zero_q;

  logic [DW-1:0] diff_abs, span_abs;
  logic [NW:0]   prod;
  logic [DW-1:0] trial;
  logic [DW:0]   sub;
  logic          fits;

  // Magnitudes and the scaled numerator, formed in the preparation step.
  assign diff_abs = diff_q[DW-1] ? (DW'(0) - diff_q) : diff_q;
  assign span_abs = span_q[DW-1] ? (DW'(0) - span_q) : span_q;
  assign prod     = (NW + 1)'(diff_abs[MW-1:0]) * (NW + 1)'(jcm_pkg::SCALE_SPAN);

  // One quotient bit per cycle.
  assign trial = {rem_q, quo_q[NW-1]};
  assign sub   = {1'b0, trial} - {2'b00, dmag_q};
  assign fits  = ~sub[DW];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jcm_pkg::DV_IDLE: if (start_i) state_d = jcm_pkg::DV_PREP;
      jcm_pkg::DV_PREP: state_d = jcm_pkg::DV_RUN;
      jcm_pkg::DV_RUN:  if (cnt_q == CNT_LAST) state_d = jcm_pkg::DV_DONE;
      jcm_pkg::DV_DONE: state_d = jcm_pkg::DV_IDLE;
      default:          state_d = jcm_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (state_q == jcm_pkg::DV_PREP) begin
      cnt_d = '0;
    end else if (state_q == jcm_pkg::DV_RUN) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jcm_pkg::DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      jcm_pkg::DV_IDLE: begin
        if (start_i) begin
          diff_q <= {2'b00, sample_i} - {1'b0, low_i};
          span_q <= {1'b0, high_i} - {1'b0, low_i};
        end
      end
      jcm_pkg::DV_PREP: begin
        dmag_q <= span_abs[MW-1:0];
        quo_q  <= prod[NW-1:0];
        rem_q  <= '0;
        neg_q  <= diff_q[DW-1] ^ span_q[DW-1];
        zero_q <= (span_q == '0);
      end
      jcm_pkg::DV_RUN: begin
        rem_q <= fits ? sub[MW-1:0] : trial[MW-1:0];
        quo_q <= {quo_q[NW-2:0], fits};
      end
      default: begin
      end
    endcase
  end

  // A negative quotient always lands at or below the lower limit.
  always_comb begin
    if (zero_q) begin
      value_o = '0;
    end else if (neg_q) begin
      value_o = jcm_pkg::AXIS_MIN;
    end else if (quo_q >= NW'(jcm_pkg::SCALE_SPAN)) begin
      value_o = jcm_pkg::AXIS_MAX;
    end else begin
      value_o = quo_q[7:0] - jcm_pkg::AXIS_MAX;
    end
  end

  always_comb begin
    stat_o.done      = (state_q == jcm_pkg::DV_DONE);
    stat_o.zero_span = zero_q;
  end

endmodule

### hdl/two_axis_joystick_calibrate_map.sv
// In controller mode an accepted sample beat goes through PITCH_GO, PITCH_WAIT, ROLL_GO,
// ROLL_WAIT and LOAD before the report is loaded; a calibration item goes straight to LOAD.
// No new sample beat is taken until the report is loaded, as the single bit-serial divider
// handles pitch and then roll; LOAD waits while the output register holds an untaken report.
// Reset (asynchronous, active low): controller mode, lower bounds 2^SAMPLE_BITS, upper bounds 0,
// no report held.
module two_axis_joystick_calibrate_map #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jcm_in_if.sink    in_i,
  jcm_out_if.source out_o
);

  // The item sequencer. An accepted beat toggles the mode when the button
  // was released. In calibration the bounds widen at once and the report
  // is loaded once the output is free; in controller mode the shared
  // divider maps pitch first and then roll before the report is loaded.
  jcm_pkg::jcm_state_e state_q, state_d;

  logic in_fire;
  logic in_ready;
  logic div_start;
  logic load_out;
  logic out_free;
  logic sel_roll;
  logic new_cal;

  // Mode flags.
  logic cal_q, cal_d;
  logic save_q, save_d;

  // Captured samples and mapped results.
  logic [SAMPLE_BITS-1:0] pitch_q, roll_q;
  logic signed [7:0]      x_q, y_q;
  logic                   pitch_zero_q, roll_zero_q;

  // Bounds.
  logic [SAMPLE_BITS:0] pitch_low, pitch_high, roll_low, roll_high;

  // Divider.
  logic [SAMPLE_BITS-1:0] div_sample;
  logic [SAMPLE_BITS:0]   div_low, div_high;
  logic signed [7:0]      div_value;
  jcm_pkg::jcm_div_stat_t div_stat;

  // Output register: it decouples the report from the sample side, so a new
  // sample beat is taken while the previous report still waits.
  logic                  out_valid_q, out_valid_d;
  logic                  rep_q;
  logic signed [7:0]     out_x_q, out_y_q;
  logic                  out_cal_q, out_save_q, out_err_q;
  logic [SAMPLE_BITS:0]  out_pl_q, out_ph_q, out_rl_q, out_rh_q;

  assign in_fire  = in_i.valid & in_ready;
  assign new_cal  = cal_q ^ in_i.button_released;
  assign out_free = ~out_valid_q | out_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jcm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = new_cal ? jcm_pkg::ST_LOAD : jcm_pkg::ST_PITCH_GO;
        end
      end
      jcm_pkg::ST_PITCH_GO:   state_d = jcm_pkg::ST_PITCH_WAIT;
      jcm_pkg::ST_PITCH_WAIT: if (div_stat.done) state_d = jcm_pkg::ST_ROLL_GO;
      jcm_pkg::ST_ROLL_GO:    state_d = jcm_pkg::ST_ROLL_WAIT;
      jcm_pkg::ST_ROLL_WAIT:  if (div_stat.done) state_d = jcm_pkg::ST_LOAD;
      jcm_pkg::ST_LOAD:       if (out_free) state_d = jcm_pkg::ST_IDLE;
      default:                state_d = jcm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    sel_roll  = 1'b0;
    unique case (state_q)
      jcm_pkg::ST_IDLE:     in_ready = 1'b1;
      jcm_pkg::ST_PITCH_GO: div_start = 1'b1;
      jcm_pkg::ST_ROLL_GO: begin
        div_start = 1'b1;
        sel_roll  = 1'b1;
      end
      jcm_pkg::ST_LOAD:     load_out = out_free;
      default: begin
      end
    endcase
  end

  assign in_i.ready = in_ready;

  // Mode toggles on the accepted beat; the save strobe marks leaving calibration.
  always_comb begin
    cal_d  = cal_q;
    save_d = save_q;
    if (in_fire) begin
      cal_d  = new_cal;
      save_d = cal_q & ~new_cal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jcm_pkg::ST_IDLE;
      cal_q       <= 1'b0;
      save_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cal_q       <= cal_d;
      save_q      <= save_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Sample capture and mapped results.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pitch_q <= in_i.pitch_sample;
      roll_q  <= in_i.roll_sample;
    end
    if ((state_q == jcm_pkg::ST_PITCH_WAIT) && div_stat.done) begin
      y_q          <= div_value;
      pitch_zero_q <= div_stat.zero_span;
    end
    if ((state_q == jcm_pkg::ST_ROLL_WAIT) && div_stat.done) begin
      x_q         <= -div_value;
      roll_zero_q <= div_stat.zero_span;
    end
  end

  // Report register. Calibration reports carry zero axes and no span error.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rep_q      <= ~cal_q;
      out_x_q    <= cal_q ? 8'sd0 : x_q;
      out_y_q    <= cal_q ? 8'sd0 : y_q;
      out_cal_q  <= cal_q;
      out_save_q <= save_q;
      out_err_q  <= ~cal_q & (pitch_zero_q | roll_zero_q);
      out_pl_q   <= pitch_low;
      out_ph_q   <= pitch_high;
      out_rl_q   <= roll_low;
      out_rh_q   <= roll_high;
    end
  end

  jcm_bounds #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_bounds (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .update_i     (in_fire & new_cal),
    .pitch_i      (in_i.pitch_sample),
    .roll_i       (in_i.roll_sample),
    .pitch_low_o  (pitch_low),
    .pitch_high_o (pitch_high),
    .roll_low_o   (roll_low),
    .roll_high_o  (roll_high)
  );

  // The divider takes its operands only on the start cycle.
  assign div_sample = sel_roll ? roll_q : pitch_q;
  assign div_low    = sel_roll ? roll_low : pitch_low;
  assign div_high   = sel_roll ? roll_high : pitch_high;

  jcm_serial_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .sample_i (div_sample),
    .low_i    (div_low),
    .high_i   (div_high),
    .value_o  (div_value),
    .stat_o   (div_stat)
  );

  assign out_o.valid            = out_valid_q;
  assign out_o.report_valid     = rep_q;
  assign out_o.x_axis           = out_x_q;
  assign out_o.y_axis           = out_y_q;
  assign out_o.in_calibration   = out_cal_q;
  assign out_o.save_strobe      = out_save_q;
  assign out_o.saved_pitch_low  = out_pl_q;
  assign out_o.saved_pitch_high = out_ph_q;
  assign out_o.saved_roll_low   = out_rl_q;
  assign out_o.saved_roll_high  = out_rh_q;
  assign out_o.span_error       = out_err_q;

endmodule

### hdl/jcm_checker.sv
// Port-level checks on the report channel, bound to the top level.
module jcm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              ready_i,
  input logic              report_valid_i,
  input logic signed [7:0] x_axis_i,
  input logic signed [7:0] y_axis_i,
  input logic              in_calibration_i,
  input logic              save_strobe_i,
  input logic              span_error_i
);

  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (report_valid_i != in_calibration_i))
    else $error("report valid and calibration flag disagree");

  a_save_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && save_strobe_i |-> report_valid_i)
    else $error("save strobe outside controller mode");

  a_cal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !report_valid_i |-> (x_axis_i == 8'sd0) && (y_axis_i == 8'sd0) && !span_error_i)
    else $error("calibration beat carries axis data");

  a_save_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && save_strobe_i |=> !(valid_i && save_strobe_i))
    else $error("save strobe on two beats in a row");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(x_axis_i) && $stable(y_axis_i))
    else $error("stalled report beat changed");

endmodule

bind two_axis_joystick_calibrate_map jcm_checker u_jcm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (out_o.valid),
  .ready_i          (out_o.ready),
  .report_valid_i   (out_o.report_valid),
  .x_axis_i         (out_o.x_axis),
  .y_axis_i         (out_o.y_axis),
  .in_calibration_i (out_o.in_calibration),
  .save_strobe_i    (out_o.save_strobe),
  .span_error_i     (out_o.span_error)
);

### verif/two_axis_joystick_calibrate_map_tb.sv
// Self-checking testbench for the joystick calibrate-and-map block.
`timescale 1ns / 100ps

module two_axis_joystick_calibrate_map_tb;

  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam logic [SAMPLE_BITS:0] LOW_BOUND_RESET = (SAMPLE_BITS + 1)'(1) << SAMPLE_BITS;
  // Time allowed for draining after the last owed report.
  localparam int DRAIN_CYCLES = 80;

  // One sample beat as the sender presents it.
  typedef struct {
    logic                   button_released;
    logic [SAMPLE_BITS-1:0] pitch_sample;
    logic [SAMPLE_BITS-1:0] roll_sample;
  } sample_beat_t;

  // One report beat as the block should produce it.
  typedef struct {
    logic                  report_valid;
    logic signed [7:0]     x_axis;
    logic signed [7:0]     y_axis;
    logic                  in_calibration;
    logic                  save_strobe;
    logic [SAMPLE_BITS:0]  saved_pitch_low;
    logic [SAMPLE_BITS:0]  saved_pitch_high;
    logic [SAMPLE_BITS:0]  saved_roll_low;
    logic [SAMPLE_BITS:0]  saved_roll_high;
    logic                  span_error;
  } report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jcm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
  jcm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) rpt_if ();

  two_axis_joystick_calibrate_map #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .out_o  (rpt_if)
  );

  always #4 clk_i = ~clk_i;

  // Beats still to be sent, and the reports that accepted beats are owed.
  sample_beat_t sample_beats[$];
  report_t      reports_owed[$];
  int unsigned  mismatches = 0;

  // Shadow of the block's mode and calibration bounds, updated on every accepted beat.
  logic                 cal_mode;
  logic [SAMPLE_BITS:0] pitch_lo, pitch_hi, roll_lo, roll_hi;

  // Linear map of one axis onto -127..127. The divide truncates towards zero, exactly as a
  // signed integer divide does, and a negative span (bounds inverted, as after reset) is
  // used as it stands before the result is clamped.
  function automatic logic signed [7:0] map_to_axis(logic [SAMPLE_BITS-1:0] s,
                                                    logic [SAMPLE_BITS:0] lo,
                                                    logic [SAMPLE_BITS:0] hi,
                                                    inout logic zero_span);
    longint span;
    longint v;
    span = longint'(hi) - longint'(lo);
    if (span == 0) begin
      zero_span = 1'b1;
      return 8'sd0;
    end
    v = (longint'(s) - longint'(lo)) * longint'(jcm_pkg::SCALE_SPAN) / span
        + longint'(jcm_pkg::AXIS_MIN);
    if (v > longint'(jcm_pkg::AXIS_MAX)) v = longint'(jcm_pkg::AXIS_MAX);
    if (v < longint'(jcm_pkg::AXIS_MIN)) v = longint'(jcm_pkg::AXIS_MIN);
    return v[7:0];
  endfunction

  // Works out the report for one accepted beat and advances the shadow state.
  function automatic report_t predict_report(sample_beat_t b);
    report_t r;
    logic    was_cal;
    logic    zero_span;
    was_cal   = cal_mode;
    zero_span = 1'b0;
    r.report_valid = 1'b0;
    r.x_axis       = 8'sd0;
    r.y_axis       = 8'sd0;
    // A release flips the mode before the samples of the same beat are used.
    if (b.button_released) cal_mode = ~cal_mode;
    if (cal_mode) begin
      // Bounds only ever widen; entering calibration does not clear them.
      if ({1'b0, b.pitch_sample} < pitch_lo) pitch_lo = {1'b0, b.pitch_sample};
      if ({1'b0, b.pitch_sample} > pitch_hi) pitch_hi = {1'b0, b.pitch_sample};
      if ({1'b0, b.roll_sample} < roll_lo) roll_lo = {1'b0, b.roll_sample};
      if ({1'b0, b.roll_sample} > roll_hi) roll_hi = {1'b0, b.roll_sample};
    end else begin
      r.report_valid = 1'b1;
      r.y_axis = map_to_axis(b.pitch_sample, pitch_lo, pitch_hi, zero_span);
      // Roll is reported negated on x; the clamped range is symmetric so this cannot wrap.
      r.x_axis = -map_to_axis(b.roll_sample, roll_lo, roll_hi, zero_span);
    end
    r.in_calibration   = cal_mode;
    r.save_strobe      = was_cal && !cal_mode;
    r.saved_pitch_low  = pitch_lo;
    r.saved_pitch_high = pitch_hi;
    r.saved_roll_low   = roll_lo;
    r.saved_roll_high  = roll_hi;
    r.span_error       = zero_span;
    return r;
  endfunction

  // Idle lengths: mostly none or short, now and then long, with runs of back-to-back beats
  // so that the block also sees pressure at full rate.
  int unsigned calm_run = 0;

  function automatic int unsigned pick_idle();
    int unsigned roll;
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      calm_run = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 45);
  endfunction

  // Sender. The beat on the bus stays put until it is taken; the prediction is made at the
  // edge of acceptance so the expectation always lines up with what the block really saw.
  int unsigned send_idle = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic         taken;
    logic         next_valid;
    sample_beat_t b;
    if (!rst_ni) begin
      smp_if.valid           <= 1'b0;
      smp_if.button_released <= 1'b0;
      smp_if.pitch_sample    <= '0;
      smp_if.roll_sample     <= '0;
    end else begin
      taken = smp_if.valid && smp_if.ready;
      if (taken) begin
        reports_owed.push_back(predict_report(sample_beats[0]));
        void'(sample_beats.pop_front());
      end
      if (smp_if.valid && !taken) begin
        next_valid = 1'b1;
      end else if (send_idle > 0) begin
        send_idle--;
        next_valid = 1'b0;
      end else if (sample_beats.size() > 0) begin
        next_valid = 1'b1;
        send_idle  = pick_idle();
      end else begin
        next_valid = 1'b0;
      end
      smp_if.valid <= next_valid;
      if (next_valid) begin
        b = sample_beats[0];
        smp_if.button_released <= b.button_released;
        smp_if.pitch_sample    <= b.pitch_sample;
        smp_if.roll_sample     <= b.roll_sample;
      end else begin
        // Junk while idle, which the block must ignore.
        smp_if.button_released <= 1'($urandom_range(0, 1));
        smp_if.pitch_sample    <= SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        smp_if.roll_sample     <= SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver. Each report beat is held against the oldest owed report, field by field.
  int unsigned recv_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    logic    next_ready;
    if (!rst_ni) begin
      rpt_if.ready <= 1'b0;
    end else begin
      if (rpt_if.valid && rpt_if.ready) begin
        if (reports_owed.size() == 0) begin
          mismatches++;
          $display("%0t ns: report beat with nothing owed, expected none, actual x=%0d y=%0d",
                   $time, rpt_if.x_axis, rpt_if.y_axis);
        end else begin
          want = reports_owed.pop_front();
          check_field("report_valid", want.report_valid, rpt_if.report_valid);
          check_field("x_axis", want.x_axis, rpt_if.x_axis);
          check_field("y_axis", want.y_axis, rpt_if.y_axis);
          check_field("in_calibration", want.in_calibration, rpt_if.in_calibration);
          check_field("save_strobe", want.save_strobe, rpt_if.save_strobe);
          check_field("saved_pitch_low", want.saved_pitch_low, rpt_if.saved_pitch_low);
          check_field("saved_pitch_high", want.saved_pitch_high, rpt_if.saved_pitch_high);
          check_field("saved_roll_low", want.saved_roll_low, rpt_if.saved_roll_low);
          check_field("saved_roll_high", want.saved_roll_high, rpt_if.saved_roll_high);
          check_field("span_error", want.span_error, rpt_if.span_error);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        recv_stall = pick_idle();
      end
      rpt_if.ready <= next_ready;
    end
  end

  // Stimulus side keeps its own idea of the mode so that well-formed sequences can be built.
  logic gen_cal = 1'b0;

  task automatic queue_beat(logic btn, int p, int r);
    sample_beat_t b;
    b.button_released = btn;
    b.pitch_sample    = p[SAMPLE_BITS-1:0];
    b.roll_sample     = r[SAMPLE_BITS-1:0];
    if (btn) gen_cal = ~gen_cal;
    sample_beats.push_back(b);
  endtask

  // Calibration sweeps mostly stay near the centre so the bounds widen slowly and the mapping
  // keeps meeting spans of many sizes; the odd sample goes out to the rails.
  function automatic int cal_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 0;
    if (roll < 6) return SAMPLE_MAX;
    if (roll < 12) return $urandom_range(0, SAMPLE_MAX);
    return $urandom_range(1600, 2500);
  endfunction

  function automatic int ctrl_sample();
    if ($urandom_range(0, 99) < 65) return $urandom_range(0, SAMPLE_MAX);
    return $urandom_range(1500, 2600);
  endfunction

  initial begin
    int n;
    cal_mode = 1'b0;
    pitch_lo = LOW_BOUND_RESET;
    pitch_hi = '0;
    roll_lo  = LOW_BOUND_RESET;
    roll_hi  = '0;
    smp_if.valid           = 1'b0;
    smp_if.button_released = 1'b0;
    smp_if.pitch_sample    = '0;
    smp_if.roll_sample     = '0;
    rpt_if.ready           = 1'b0;

    // Directed part. Straight out of reset the bounds are inverted, so the rails map with a
    // negative span onto the axis limits.
    queue_beat(1'b0, 0, 0);
    queue_beat(1'b0, SAMPLE_MAX, SAMPLE_MAX);
    queue_beat(1'b0, 2048, 1024);
    // A single calibration sample leaves both axes with equal bounds: zero span on both.
    queue_beat(1'b1, 2000, 1000);
    queue_beat(1'b1, 2000, 1000);
    queue_beat(1'b0, 0, SAMPLE_MAX);
    // Widen pitch only, so that roll alone still has a zero span; leave below the pitch range.
    queue_beat(1'b1, 2100, 1000);
    queue_beat(1'b1, 1900, 1000);
    queue_beat(1'b0, 2050, 1000);
    // Re-entering calibration keeps the old bounds and widens them further.
    queue_beat(1'b1, 2000, 900);
    queue_beat(1'b0, 2000, 1100);
    queue_beat(1'b0, 1800, 1050);
    // Leave with samples beyond both ranges, then the rails, the exact bounds and mid-points.
    queue_beat(1'b1, SAMPLE_MAX, 0);
    queue_beat(1'b0, 0, SAMPLE_MAX);
    queue_beat(1'b0, 1800, 900);
    queue_beat(1'b0, 2100, 1100);
    queue_beat(1'b0, 1950, 1000);
    // Enter and leave on consecutive beats.
    queue_beat(1'b1, 2200, 1200);
    queue_beat(1'b1, 1950, 1000);
    // Just inside the bounds, where the truncating divide matters most.
    queue_beat(1'b0, 2199, 901);
    queue_beat(1'b0, 1801, 1199);

    // Random part: mostly complete calibrate-then-use sequences with random content, the
    // rest loose beats with releases scattered among them.
    while (sample_beats.size() < 420) begin
      if ($urandom_range(0, 99) < 75) begin
        if (gen_cal) queue_beat(1'b1, ctrl_sample(), ctrl_sample());
        queue_beat(1'b1, cal_sample(), cal_sample());
        n = $urandom_range(0, 8);
        repeat (n) queue_beat(1'b0, cal_sample(), cal_sample());
        queue_beat(1'b1, ctrl_sample(), ctrl_sample());
        n = $urandom_range(2, 14);
        repeat (n) queue_beat(1'b0, ctrl_sample(), ctrl_sample());
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          queue_beat($urandom_range(0, 3) == 0, $urandom_range(0, SAMPLE_MAX),
                     $urandom_range(0, SAMPLE_MAX));
        end
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every beat has gone in and every owed report has come out.
    while (sample_beats.size() > 0 || reports_owed.size() > 0) @(posedge clk_i);
    // Give the block time to show any report it should not produce.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("two_axis_joystick_calibrate_map regression: pass");
    end else begin
      $display("two_axis_joystick_calibrate_map regression: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run of about 450 beats.
  initial begin
    #5000000;
    $display("two_axis_joystick_calibrate_map regression: fail");
    $finish;
  end

endmodule
